// ===== rtl/vbts_pkg.sv =====
package vbts_pkg;

    localparam int BrickEdge   = 8;
    localparam int BrickVoxels = BrickEdge * BrickEdge * BrickEdge;
    localparam int IdxW        = $clog2(BrickVoxels);
    localparam int CellW       = $clog2(BrickEdge);
    localparam int PosW        = 17;
    localparam int ValW        = 16;

    localparam logic [PosW-1:0] PosOne = 17'h10000;
    localparam logic [CellW:0] CellMax = (CellW+1)'(BrickEdge - 2);

    localparam logic OpWrite  = 1'b0;
    localparam logic OpSample = 1'b1;

    // Classified work item passed from the front to the back part
    typedef struct packed {
        logic             is_write;
        logic [IdxW-1:0]  widx;
        logic [ValW-1:0]  wval;
        logic [CellW-1:0] cx;
        logic [CellW-1:0] cy;
        logic [CellW-1:0] cz;
        logic [PosW-1:0]  tx;
        logic [PosW-1:0]  ty;
        logic [PosW-1:0]  tz;
    } vbts_cmd_t;

    // Lerp with floor of the 16 dropped low bits; result stays between a and b
    function automatic logic signed [ValW-1:0] lerp_q16(
        input logic signed [ValW-1:0] a,
        input logic signed [ValW-1:0] b,
        input logic [PosW-1:0]        t
    );
        logic signed [ValW:0]      d;
        logic signed [ValW+PosW+1:0] p;
        logic signed [ValW+PosW+1:0] q;
        d = 17'(b) - 17'(a);
        p = (ValW+PosW+2)'(d) * $signed({1'b0, t});
        q = p >>> 16;
        lerp_q16 = ValW'(q + (ValW+PosW+2)'(a));
    endfunction

endpackage

// ===== rtl/voxel_brick_trilinear_sampler_core.sv =====
// Trilinear sampler over one 8x8x8 brick of signed Q8.8 distances.
// Input channel s_*: s_opcode 0 writes s_voxel_value at s_voxel_index and
// gives no result; s_opcode 1 samples at (s_pos_x, s_pos_y, s_pos_z) in
// unsigned Q1.16 and gives one m_distance transfer on the m_* channel.
// A front part clamps and splits each coordinate into cell and weight and
// pushes the item into a two-entry queue; a back part owns the voxel store.
// The back part reads the eight corners one per cycle from the store's
// single read port, blending x pairs as they arrive, then blends y, then
// z, then hands the result over and returns to idle to take the next
// item; it takes a new item only when idle, so a sample is finished
// before the next item is taken. A write is stored as it is taken.
// Reset clears the queue and the control state; the voxel store keeps its
// contents and must be written before it is sampled.
// When the receiver stalls, the result is held on m_distance and the
// queue keeps taking items until it is full, then s_ready drops.
module voxel_brick_trilinear_sampler_core import vbts_pkg::*; (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  logic            s_opcode,
    input  logic [8:0]      s_voxel_index,
    input  logic signed [15:0] s_voxel_value,
    input  logic [16:0]     s_pos_x,
    input  logic [16:0]     s_pos_y,
    input  logic [16:0]     s_pos_z,
    output logic            m_valid,
    input  logic            m_ready,
    output logic signed [15:0] m_distance
);

    logic      q_valid, q_ready;
    vbts_cmd_t q_cmd;

    vbts_front u_front (
        .aclk, .aresetn, .s_valid, .s_ready, .s_opcode, .s_voxel_index,
        .s_voxel_value, .s_pos_x, .s_pos_y, .s_pos_z,
        .q_valid, .q_ready, .q_cmd
    );

    vbts_back u_back (
        .aclk, .aresetn, .q_valid, .q_ready, .q_cmd,
        .m_valid, .m_ready, .m_distance
    );

endmodule

// ===== rtl/vbts_front.sv =====
module vbts_front import vbts_pkg::*; (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  logic            s_opcode,
    input  logic [8:0]      s_voxel_index,
    input  logic signed [15:0] s_voxel_value,
    input  logic [16:0]     s_pos_x,
    input  logic [16:0]     s_pos_y,
    input  logic [16:0]     s_pos_z,
    output logic            q_valid,
    input  logic            q_ready,
    output vbts_cmd_t       q_cmd
);

    localparam int Depth = 2;

    vbts_cmd_t   fifo_reg [Depth];
    logic        wp_reg, wp_next, rp_reg, rp_next;
    logic [1:0]  cnt_reg, cnt_next;
    vbts_cmd_t   cmd;
    logic [CellW-1:0] c_x, c_y, c_z;
    logic [PosW-1:0]  t_x, t_y, t_z;
    logic        push, pop;

    // Split one coordinate into a cell and a weight
    function automatic logic [CellW+PosW-1:0] split(input logic [PosW-1:0] pos);
        logic [PosW-1:0]        c;
        logic [PosW+CellW-1:0]  p;
        logic [CellW:0]         i;
        logic [PosW-1:0]        w;
        c = (pos > PosOne) ? PosOne : pos;
        p = (PosW+CellW)'(c) * (PosW+CellW)'(BrickEdge - 1);
        i = (CellW+1)'(p >> 16);
        if (i > CellMax) i = CellMax;
        w = PosW'(p - ((PosW+CellW)'(i) << 16));
        split = {i[CellW-1:0], w};
    endfunction

    assign {c_x, t_x} = split(s_pos_x);
    assign {c_y, t_y} = split(s_pos_y);
    assign {c_z, t_z} = split(s_pos_z);

    always_comb begin
        cmd.is_write = (s_opcode == OpWrite);
        cmd.widx     = IdxW'(s_voxel_index);
        cmd.wval     = s_voxel_value;
        cmd.cx = c_x; cmd.cy = c_y; cmd.cz = c_z;
        cmd.tx = t_x; cmd.ty = t_y; cmd.tz = t_z;
    end

    assign s_ready = (cnt_reg != 2'(Depth));
    assign q_valid = (cnt_reg != 2'd0);
    assign q_cmd   = fifo_reg[rp_reg];
    assign push    = s_valid && s_ready;
    assign pop     = q_valid && q_ready;

    always_comb begin
        wp_next  = push ? ~wp_reg : wp_reg;
        rp_next  = pop ? ~rp_reg : rp_reg;
        cnt_next = cnt_reg + 2'(push) - 2'(pop);
    end

    // Hold queue pointers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg <= 1'b0; rp_reg <= 1'b0; cnt_reg <= 2'd0;
        end else begin
            wp_reg <= wp_next; rp_reg <= rp_next; cnt_reg <= cnt_next;
        end
    end

    // Store queue entries
    always_ff @(posedge aclk) begin
        if (push) fifo_reg[wp_reg] <= cmd;
    end

endmodule

// ===== rtl/vbts_back.sv =====
module vbts_back import vbts_pkg::*; (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            q_valid,
    output logic            q_ready,
    input  vbts_cmd_t       q_cmd,
    output logic            m_valid,
    input  logic            m_ready,
    output logic signed [15:0] m_distance
);

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_READ = 5'b00010,
        ST_LY   = 5'b00100,
        ST_LZ   = 5'b01000,
        ST_OUT  = 5'b10000
    } state_t;

    state_t state_reg, state_next;
    logic [3:0] rc_reg, rc_next;   // read issue counter 0..8
    logic       rv_reg;            // read data valid
    logic [2:0] rk_reg;            // corner of registered read
    vbts_cmd_t  cmd_reg;
    logic signed [ValW-1:0] mem [BrickVoxels];
    logic signed [ValW-1:0] rd_reg;
    logic signed [ValW-1:0] a_reg;
    logic signed [ValW-1:0] cx_reg [4];
    logic signed [ValW-1:0] cy_reg [2];
    logic signed [ValW-1:0] res_reg;
    logic [CellW-1:0] ax, ay, az;
    logic [IdxW-1:0]  raddr;
    logic       take;

    assign take    = q_valid && q_ready;
    assign q_ready = (state_reg == ST_IDLE);
    assign m_valid = (state_reg == ST_OUT);
    assign m_distance = res_reg;

    // Corner address: bit0 x, bit1 y, bit2 z
    always_comb begin
        ax = cmd_reg.cx + CellW'(rc_reg[0]);
        ay = cmd_reg.cy + CellW'(rc_reg[1]);
        az = cmd_reg.cz + CellW'(rc_reg[2]);
        raddr = {az, ay, ax};
    end

    always_comb begin
        state_next = state_reg;
        rc_next    = rc_reg;
        unique case (state_reg)
            ST_IDLE: if (take && !q_cmd.is_write) begin
                state_next = ST_READ;
                rc_next    = 4'd0;
            end
            ST_READ: begin
                if (rc_reg != 4'd8) rc_next = rc_reg + 4'd1;
                if (rv_reg && rk_reg == 3'd7) state_next = ST_LY;
            end
            ST_LY:  state_next = ST_LZ;
            ST_LZ:  state_next = ST_OUT;
            ST_OUT: if (m_ready) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            rc_reg    <= 4'd0;
            rv_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            rc_reg    <= rc_next;
            rv_reg    <= (state_reg == ST_READ) && (rc_reg != 4'd8);
        end
    end

    // Write voxel store and read one corner per cycle
    always_ff @(posedge aclk) begin
        if (take && q_cmd.is_write) mem[q_cmd.widx] <= q_cmd.wval;
        rd_reg <= mem[raddr];
        rk_reg <= rc_reg[2:0];
    end

    // Blend: x pairs as corners arrive, then y, then z
    always_ff @(posedge aclk) begin
        if (take) cmd_reg <= q_cmd;
        if (rv_reg) begin
            if (!rk_reg[0]) a_reg <= rd_reg;
            else cx_reg[rk_reg[2:1]] <= lerp_q16(a_reg, rd_reg, cmd_reg.tx);
        end
        if (state_reg == ST_LY) begin
            cy_reg[0] <= lerp_q16(cx_reg[0], cx_reg[1], cmd_reg.ty);
            cy_reg[1] <= lerp_q16(cx_reg[2], cx_reg[3], cmd_reg.ty);
        end
        if (state_reg == ST_LZ) res_reg <= lerp_q16(cy_reg[0], cy_reg[1], cmd_reg.tz);
    end

endmodule
